FILE: design/cne_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cne_pkg
// shared types, constants and helpers of the contrast normalized edge block
// ----------------------------------------------------------------------------
package cne_pkg;

  // geometry
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int FW_W       = 11;
  localparam int FH_W       = 13;
  localparam int PIX_W      = 8;

  // configuration port
  localparam int CFG_W      = 13;
  localparam int IDX_W      = 3;

  typedef enum logic [IDX_W-1:0] {
    REG_FRAME_WIDTH      = 3'd0,
    REG_FRAME_HEIGHT     = 3'd1,
    REG_FOUR_BIT_MODE    = 3'd2,
    REG_THRESHOLD_ENABLE = 3'd3,
    REG_THRESHOLD_HIGH   = 3'd4
  } cfg_reg_t;

  // request kinds
  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_FLUSH = 1'b1;

  // arithmetic widths
  localparam int NUM_W       = 15;  // signed edge sum, |sum| <= 9180
  localparam int TOT_W       = 12;  // sum of nine pixels
  localparam int QUO_W       = 14;  // quotient magnitude
  localparam int DIV_CNT_W   = $clog2(QUO_W);
  localparam int RECIP_W     = 13;
  localparam int RECIP_SHIFT = 16;
  localparam logic [RECIP_W-1:0] RECIP_NINE = 13'd7282;  // ceil(2^16 / 9)

  localparam int K_CENTRE = 36;
  localparam int K_CORNER = 9;

  // output levels
  localparam logic [PIX_W-1:0] LIM_8BIT = 8'd255;
  localparam logic [PIX_W-1:0] LIM_4BIT = 8'd16;
  localparam logic [PIX_W-1:0] HI_8BIT  = 8'd250;
  localparam logic [PIX_W-1:0] LO_8BIT  = 8'd16;
  localparam logic [PIX_W-1:0] HI_4BIT  = 8'd10;
  localparam logic [PIX_W-1:0] LO_4BIT  = 8'd3;

  typedef struct packed {
    logic             start;
    logic [QUO_W-1:0] dividend;
    logic [PIX_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quotient;
  } div_res_t;

  function automatic logic [PIX_W-1:0] finish_value(input logic [PIX_W-1:0] v,
                                                    input logic thr_en,
                                                    input logic four_bit,
                                                    input logic [PIX_W-1:0] thr);
    logic [PIX_W-1:0] r;
    if (!thr_en) begin
      r = v;
    end else if (v > thr) begin
      r = four_bit ? HI_4BIT : HI_8BIT;
    end else begin
      r = four_bit ? LO_4BIT : LO_8BIT;
    end
    return r;
  endfunction

endpackage

FILE: design/cne_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cne stream interfaces
// pixel request channel and edge result channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface cne_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] pixel;

  modport source (output valid, output req_type, output pixel, input ready);
  modport sink   (input valid, input req_type, input pixel, output ready);
endinterface

interface cne_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  edge_value;
  logic [11:0] out_row;
  logic [9:0]  out_col;
  logic        end_of_frame;
  logic        last_of_run;

  modport source (output valid, output edge_value, output out_row, output out_col,
                  output end_of_frame, output last_of_run, input ready);
  modport sink   (input valid, input edge_value, input out_row, input out_col,
                  input end_of_frame, input last_of_run, output ready);
endinterface

FILE: design/cne_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cne_ram
// generic single port ram, registered read
// ----------------------------------------------------------------------------
module cne_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: design/cne_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cne_divider
// radix-2 restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module cne_divider (
  input  logic              clk,
  input  logic              rst,
  input  cne_pkg::div_req_t req,
  output cne_pkg::div_res_t res
);
  import cne_pkg::*;

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [PIX_W-1:0]     rem;
  logic [QUO_W-1:0]     quo;
  logic [PIX_W-1:0]     dsr;
  logic [PIX_W:0]       partial;
  logic [PIX_W:0]       diff;
  logic                 fits;
  logic                 last_step;

  assign partial   = {rem, quo[QUO_W-1]};
  assign fits      = partial >= {1'b0, dsr};
  assign diff      = partial - {1'b0, dsr};
  assign last_step = (cnt == DIV_CNT_W'(QUO_W - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (last_step) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // remainder stays below the divisor, so it fits the pixel width
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      quo <= req.dividend;
      dsr <= req.divisor;
    end else if (busy) begin
      rem <= fits ? diff[PIX_W-1:0] : partial[PIX_W-1:0];
      quo <= {quo[QUO_W-2:0], fits};
    end
  end

  assign res.done     = done;
  assign res.quotient = quo;

  assert property (@(posedge clk) disable iff (rst) req.start |-> !busy)
    else $error("divider restarted while busy");
  assert property (@(posedge clk) disable iff (rst) (busy && last_step) |=> done)
    else $error("divider missed its done pulse");
  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("divider done while still busy");

endmodule

FILE: design/contrast_normalized_edge_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// contrast_normalized_edge_top
// 3x3 contrast normalized edge detector over a raster pixel stream
// ----------------------------------------------------------------------------
// path: an interior pixel goes from request to result register through read, window,
//   sums, mean, 14 divider steps and load; no positive edge sum skips the divider,
//   a border pixel skips sums, mean and divider; flow: one request at a time,
//   set by the 14-step radix-2 divider; a second result at row end adds a state
// reset: synchronous, clears counters, drain flag, fsm and config to defaults;
//   line store contents stay undefined until written
module contrast_normalized_edge_top (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [cne_pkg::IDX_W-1:0] cfg_index,
  input  logic [cne_pkg::CFG_W-1:0] cfg_data,
  cne_in_if.sink                    pix_in,
  cne_out_if.source                 edge_out
);
  import cne_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_SUM,
    S_SCALE,
    S_DIV,
    S_PUT1,
    S_PUT2,
    S_FLUSH
  } state_t;

  state_t state;

  // configuration registers
  logic [FW_W-1:0]  frame_width;
  logic [FH_W-1:0]  frame_height;
  logic             four_bit_mode;
  logic             threshold_enable;
  logic [PIX_W-1:0] threshold_high;
  logic [FW_W-1:0]  eff_w;
  logic [FH_W-1:0]  eff_h;

  // frame position
  logic [ROW_W-1:0] row_cnt;
  logic [COL_W-1:0] col_cnt;
  logic [COL_W-1:0] flush_cnt;
  logic             draining;

  // request being worked on
  logic [ROW_W-1:0] cur_r;
  logic [COL_W-1:0] cur_c;
  logic [PIX_W-1:0] cur_px;

  // window and arithmetic
  logic [PIX_W-1:0] win [9];
  logic [NUM_W-1:0] num;
  logic [TOT_W-1:0] tot;
  logic [PIX_W-1:0] edge_val;

  // line stores
  logic [COL_W-1:0] ram_addr;
  logic             ram_we;
  logic [PIX_W-1:0] upper_rd;
  logic [PIX_W-1:0] lower_rd;

  // result register
  logic             res_valid;
  logic [PIX_W-1:0] res_value;
  logic [ROW_W-1:0] res_row;
  logic [COL_W-1:0] res_col;
  logic             res_eof;
  logic             res_last;

  div_req_t div_req;
  div_res_t div_res;

  logic                     in_acc;
  logic                     out_free;
  logic                     out_load;
  logic [FW_W-1:0]          col_inc;
  logic [FH_W-1:0]          row_inc;
  logic                     col_wrap;
  logic                     row_wrap;
  logic                     has_out;
  logic                     interior;
  logic                     second;
  logic                     flush_eof;
  logic [NUM_W-1:0]         num_next;
  logic [TOT_W-1:0]         tot_next;
  logic [PIX_W+1:0]         corners;
  logic                     num_pos;
  logic [TOT_W+RECIP_W-1:0] mean_prod;
  logic [PIX_W-1:0]         mean;
  logic [PIX_W-1:0]         lim;
  logic [PIX_W-1:0]         clamped;
  logic [FW_W-1:0]          flush_inc;

  // size registers saturated to the supported range
  always_comb begin
    if (frame_width < FW_W'(3)) begin
      eff_w = FW_W'(3);
    end else if (frame_width > FW_W'(MAX_WIDTH)) begin
      eff_w = FW_W'(MAX_WIDTH);
    end else begin
      eff_w = frame_width;
    end
    if (frame_height < FH_W'(3)) begin
      eff_h = FH_W'(3);
    end else if (frame_height > FH_W'(MAX_HEIGHT)) begin
      eff_h = FH_W'(MAX_HEIGHT);
    end else begin
      eff_h = frame_height;
    end
  end

  // handshake
  assign pix_in.ready = (state == S_IDLE);
  assign in_acc       = pix_in.valid && pix_in.ready;
  assign out_free     = !res_valid || edge_out.ready;
  assign out_load     = out_free &&
                        (state == S_PUT1 || state == S_PUT2 || state == S_FLUSH);

  // position bookkeeping for the request in flight
  assign col_inc   = {1'b0, cur_c} + 1'b1;
  assign row_inc   = {1'b0, cur_r} + 1'b1;
  assign col_wrap  = col_inc >= eff_w;
  assign row_wrap  = row_inc >= eff_h;
  assign second    = (col_inc == eff_w);
  // results trail by one row and one column; interior needs two of each
  assign has_out   = (cur_r != '0) && (cur_c != '0);
  assign interior  = (cur_r >= ROW_W'(2)) && (cur_c >= COL_W'(2));
  assign flush_inc = {1'b0, flush_cnt} + 1'b1;
  assign flush_eof = flush_inc >= eff_w;

  // line store port: read at request time, write back in the next cycle
  assign ram_addr = (state == S_LOAD) ? cur_c : col_cnt;
  assign ram_we   = (state == S_LOAD);

  cne_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (lower_rd),
    .rdata (upper_rd)
  );

  cne_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_lower (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (cur_px),
    .rdata (lower_rd)
  );

  // edge sum 36*centre - 9*corners and window total
  assign corners  = (PIX_W+2)'(win[0]) + (PIX_W+2)'(win[2]) +
                    (PIX_W+2)'(win[6]) + (PIX_W+2)'(win[8]);
  assign num_next = NUM_W'(win[4]) * NUM_W'(K_CENTRE) - NUM_W'(corners) * NUM_W'(K_CORNER);
  assign tot_next = TOT_W'(win[0]) + TOT_W'(win[1]) + TOT_W'(win[2]) +
                    TOT_W'(win[3]) + TOT_W'(win[4]) + TOT_W'(win[5]) +
                    TOT_W'(win[6]) + TOT_W'(win[7]) + TOT_W'(win[8]);

  // mean = tot / 9 by reciprocal multiply, exact over the total's range
  assign mean_prod = (TOT_W+RECIP_W)'(tot) * (TOT_W+RECIP_W)'(RECIP_NINE);
  assign mean      = mean_prod[RECIP_SHIFT +: PIX_W];

  // non-positive sums truncate to zero or below, which clamps to zero
  assign num_pos = !num[NUM_W-1] && (num != '0);

  assign div_req.start    = (state == S_SCALE) && num_pos;
  assign div_req.dividend = num[QUO_W-1:0];
  assign div_req.divisor  = (mean == '0) ? PIX_W'(1) : mean;

  cne_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .res (div_res)
  );

  assign lim     = four_bit_mode ? LIM_4BIT : LIM_8BIT;
  assign clamped = (div_res.quotient > QUO_W'(lim)) ? lim : div_res.quotient[PIX_W-1:0];

  // sequencer, counters, configuration and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      row_cnt          <= '0;
      col_cnt          <= '0;
      flush_cnt        <= '0;
      draining         <= 1'b0;
      res_valid        <= 1'b0;
      frame_width      <= FW_W'(1024);
      frame_height     <= FH_W'(1024);
      four_bit_mode    <= 1'b0;
      threshold_enable <= 1'b0;
      threshold_high   <= PIX_W'(128);
    end else begin
      if (out_load) begin
        res_valid <= 1'b1;
      end else if (edge_out.ready) begin
        res_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_acc) begin
            if (pix_in.req_type == REQ_FLUSH) begin
              if (draining) begin
                state <= S_FLUSH;
              end
            end else if (!draining) begin
              state <= S_LOAD;
            end
          end
        end
        S_LOAD: begin
          // advance raster position; end of frame starts the final-row drain
          if (col_wrap) begin
            col_cnt <= '0;
            if (row_wrap) begin
              row_cnt   <= '0;
              flush_cnt <= '0;
              draining  <= 1'b1;
            end else begin
              row_cnt <= row_inc[ROW_W-1:0];
            end
          end else begin
            col_cnt <= col_inc[COL_W-1:0];
          end
          if (!has_out) begin
            state <= S_IDLE;
          end else if (interior) begin
            state <= S_SUM;
          end else begin
            state <= S_PUT1;
          end
        end
        S_SUM: begin
          state <= S_SCALE;
        end
        S_SCALE: begin
          state <= num_pos ? S_DIV : S_PUT1;
        end
        S_DIV: begin
          if (div_res.done) begin
            state <= S_PUT1;
          end
        end
        S_PUT1: begin
          if (out_free) begin
            state <= second ? S_PUT2 : S_IDLE;
          end
        end
        S_PUT2: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        S_FLUSH: begin
          if (out_free) begin
            if (flush_eof) begin
              row_cnt   <= '0;
              col_cnt   <= '0;
              flush_cnt <= '0;
              draining  <= 1'b0;
            end else begin
              flush_cnt <= flush_inc[COL_W-1:0];
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      // user writes only while idle, unchecked by block; size change restarts frame
      if (cfg_we) begin
        case (cfg_index)
          REG_FRAME_WIDTH: begin
            frame_width <= cfg_data[FW_W-1:0];
            row_cnt     <= '0;
            col_cnt     <= '0;
            flush_cnt   <= '0;
            draining    <= 1'b0;
          end
          REG_FRAME_HEIGHT: begin
            frame_height <= cfg_data[FH_W-1:0];
            row_cnt      <= '0;
            col_cnt      <= '0;
            flush_cnt    <= '0;
            draining     <= 1'b0;
          end
          REG_FOUR_BIT_MODE:    four_bit_mode    <= cfg_data[0];
          REG_THRESHOLD_ENABLE: threshold_enable <= cfg_data[0];
          REG_THRESHOLD_HIGH:   threshold_high   <= cfg_data[PIX_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cur_r  <= row_cnt;
      cur_c  <= col_cnt;
      cur_px <= pix_in.pixel;
    end

    if (state == S_LOAD) begin
      // shift window left, new column from the line stores and the pixel
      win[0]   <= win[1];
      win[1]   <= win[2];
      win[2]   <= upper_rd;
      win[3]   <= win[4];
      win[4]   <= win[5];
      win[5]   <= lower_rd;
      win[6]   <= win[7];
      win[7]   <= win[8];
      win[8]   <= cur_px;
      edge_val <= '0;
    end

    if (state == S_SUM) begin
      num <= num_next;
      tot <= tot_next;
    end

    if (state == S_DIV && div_res.done) begin
      edge_val <= clamped;
    end

    if (out_load) begin
      case (state)
        S_PUT1: begin
          res_value <= finish_value(edge_val, threshold_enable, four_bit_mode,
                                    threshold_high);
          res_row   <= cur_r - 1'b1;
          res_col   <= cur_c - 1'b1;
          res_eof   <= 1'b0;
          res_last  <= !second;
        end
        S_PUT2: begin
          // right border position of the row just completed
          res_value <= finish_value('0, threshold_enable, four_bit_mode, threshold_high);
          res_row   <= cur_r - 1'b1;
          res_col   <= eff_w[COL_W-1:0] - 1'b1;
          res_eof   <= 1'b0;
          res_last  <= 1'b1;
        end
        S_FLUSH: begin
          // bottom border row, one position per flush request
          res_value <= finish_value('0, threshold_enable, four_bit_mode, threshold_high);
          res_row   <= eff_h[ROW_W-1:0] - 1'b1;
          res_col   <= flush_cnt;
          res_eof   <= flush_eof;
          res_last  <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign edge_out.valid        = res_valid;
  assign edge_out.edge_value   = res_value;
  assign edge_out.out_row      = res_row;
  assign edge_out.out_col      = res_col;
  assign edge_out.end_of_frame = res_eof;
  assign edge_out.last_of_run  = res_last;

  assert property (@(posedge clk) disable iff (rst)
                   draining |-> (row_cnt == '0 && col_cnt == '0))
    else $error("raster position moved while draining");
  assert property (@(posedge clk) disable iff (rst) ({1'b0, col_cnt} < eff_w))
    else $error("column counter beyond frame width");
  assert property (@(posedge clk) disable iff (rst)
                   (state == S_DIV && div_res.done) |=> (state == S_PUT1))
    else $error("divider result not taken");
  assert property (@(posedge clk) disable iff (rst) (state == S_PUT2) |-> second)
    else $error("second result outside the last column");

endmodule

FILE: bench/tb_contrast_normalized_edge_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_contrast_normalized_edge_top
// streams pixel and flush requests through the edge detector under random
// sender bursts and receiver stalls; a local window predictor computes every
// edge result, which is checked in order against the output channel
// ----------------------------------------------------------------------------
module tb_contrast_normalized_edge_top;
  import cne_pkg::*;

  localparam int SMALL_ITEMS    = 1850;  // random requests over all phases
  localparam int SETTLE_CYCLES  = 40;    // covers the path of an interior request
  localparam int HOLD_CYCLES    = 400;   // long receiver hold-off
  localparam int PRESSURE_PHASE = 3;
  localparam int WIDE_PHASE     = 6;

  typedef struct packed {
    logic             kind;
    logic [PIX_W-1:0] pixel;
  } pixel_request_t;

  typedef struct packed {
    logic [PIX_W-1:0] edge_value;
    logic [ROW_W-1:0] out_row;
    logic [COL_W-1:0] out_col;
    logic             end_of_frame;
    logic             last_of_run;
  } edge_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we;
  cfg_reg_t cfg_index;
  logic [CFG_W-1:0] cfg_data;

  cne_in_if  pix_ch ();
  cne_out_if edge_ch ();

  contrast_normalized_edge_top dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .pix_in   (pix_ch),
    .edge_out (edge_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // window predictor: own copy of line stores, window, counters and registers
  // --------------------------------------------------------------------------
  logic [PIX_W-1:0] upper_line [MAX_WIDTH];
  logic [PIX_W-1:0] lower_line [MAX_WIDTH];
  logic [PIX_W-1:0] win_px [9];
  int unsigned cur_row, cur_col, flush_col;
  bit          draining;

  int unsigned      width_reg, height_reg;
  bit               four_bit_reg, thr_en_reg;
  logic [PIX_W-1:0] thr_reg;

  edge_result_t   edge_results_due [$];   // predicted results, oldest first
  pixel_request_t requests_to_send [$];   // requests not yet offered

  function automatic int unsigned active_width();
    if (width_reg < 3) return 3;
    if (width_reg > MAX_WIDTH) return MAX_WIDTH;
    return width_reg;
  endfunction

  function automatic int unsigned active_height();
    if (height_reg < 3) return 3;
    if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
    return height_reg;
  endfunction

  function automatic void restart_frame();
    cur_row   = 0;
    cur_col   = 0;
    flush_col = 0;
    draining  = 1'b0;
  endfunction

  // clamp result mapped to the binary levels when thresholding is on
  function automatic logic [PIX_W-1:0] output_level(int v);
    if (!thr_en_reg) return v[PIX_W-1:0];
    if (v > int'(thr_reg)) return four_bit_reg ? HI_4BIT : HI_8BIT;
    return four_bit_reg ? LO_4BIT : LO_8BIT;
  endfunction

  // edge sum over the window divided by its mean, truncated toward zero and clamped
  function automatic int contrast_quotient();
    int num, tot, mean, q, lim, k;
    num = K_CENTRE * int'(win_px[4])
        - K_CORNER * (int'(win_px[0]) + int'(win_px[2]) + int'(win_px[6]) + int'(win_px[8]));
    tot = 0;
    for (k = 0; k < 9; k++) tot += int'(win_px[k]);
    mean = tot / 9;
    if (mean == 0) mean = 1;
    q   = num / mean;
    lim = four_bit_reg ? int'(LIM_4BIT) : int'(LIM_8BIT);
    if (q > lim) q = lim;
    if (q < 0) q = 0;
    return q;
  endfunction

  // one accepted request: update the window and queue the results it causes
  function automatic void advance_edge_window(logic kind, logic [PIX_W-1:0] px);
    int unsigned  w, h, r, c;
    int           k, v;
    edge_result_t res;
    w = active_width();
    h = active_height();
    if (kind == REQ_FLUSH) begin
      // flush outside the drain is ignored
      if (!draining) return;
      res.edge_value   = output_level(0);
      res.out_row      = ROW_W'(h - 1);
      res.out_col      = COL_W'(flush_col);
      res.end_of_frame = (flush_col + 1 >= w);
      res.last_of_run  = 1'b1;
      edge_results_due.push_back(res);
      if (res.end_of_frame) restart_frame();
      else flush_col++;
      return;
    end
    // pixel while the last row is owed is dropped
    if (draining) return;
    r = cur_row;
    c = cur_col;
    for (k = 0; k < 3; k++) begin
      win_px[k*3]   = win_px[k*3+1];
      win_px[k*3+1] = win_px[k*3+2];
    end
    win_px[2]     = upper_line[c];
    win_px[5]     = lower_line[c];
    win_px[8]     = px;
    upper_line[c] = lower_line[c];
    lower_line[c] = px;
    if (r >= 1 && c >= 1) begin
      v = 0;
      if (r >= 2 && r + 1 <= h && c >= 2 && c + 1 <= w) v = contrast_quotient();
      res.edge_value   = output_level(v);
      res.out_row      = ROW_W'(r - 1);
      res.out_col      = COL_W'(c - 1);
      res.end_of_frame = 1'b0;
      res.last_of_run  = (c + 1 != w);
      edge_results_due.push_back(res);
      // last column also closes the right border of the row above
      if (c + 1 == w) begin
        res.edge_value  = output_level(0);
        res.out_col     = COL_W'(w - 1);
        res.last_of_run = 1'b1;
        edge_results_due.push_back(res);
      end
    end
    cur_col++;
    if (cur_col >= w) begin
      cur_col = 0;
      cur_row++;
      if (cur_row >= h) begin
        cur_row   = 0;
        flush_col = 0;
        draining  = 1'b1;
      end
    end
  endfunction

  // --------------------------------------------------------------------------
  // request driver: bursts of random length separated by random gaps
  // --------------------------------------------------------------------------
  int             burst_left, gap_left;
  pixel_request_t next_req;

  always @(posedge clk) begin
    if (rst) begin
      pix_ch.valid    <= 1'b0;
      pix_ch.req_type <= REQ_PIXEL;
      pix_ch.pixel    <= '0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (pix_ch.valid && pix_ch.ready)
        advance_edge_window(pix_ch.req_type, pix_ch.pixel);
      if (!pix_ch.valid || pix_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          pix_ch.valid <= 1'b0;
        end else if (requests_to_send.size() != 0) begin
          next_req = requests_to_send.pop_front();
          pix_ch.valid    <= 1'b1;
          pix_ch.req_type <= next_req.kind;
          pix_ch.pixel    <= next_req.pixel;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            // a third of the bursts run straight into the next one
            burst_left = $urandom_range(1, 32);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          pix_ch.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // result monitor: ready follows a stall style that is redrawn whenever its random
  // pattern count runs out; receiver_hold forces a long hold-off
  // --------------------------------------------------------------------------
  logic         receiver_hold = 1'b0;
  int           pattern_left, stall_style, mismatch_count = 0;
  bit           take;
  edge_result_t seen, want;

  always @(posedge clk) begin
    if (rst) begin
      edge_ch.ready <= 1'b0;
      pattern_left = 0;
      stall_style  = 0;
    end else begin
      if (edge_ch.valid && edge_ch.ready) begin
        seen.edge_value   = edge_ch.edge_value;
        seen.out_row      = edge_ch.out_row;
        seen.out_col      = edge_ch.out_col;
        seen.end_of_frame = edge_ch.end_of_frame;
        seen.last_of_run  = edge_ch.last_of_run;
        if (edge_results_due.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result: value %0d row %0d col %0d eof %0b last %0b",
                     seen.edge_value, seen.out_row, seen.out_col, seen.end_of_frame,
                     seen.last_of_run);
        end else begin
          want = edge_results_due.pop_front();
          if (seen.edge_value !== want.edge_value || seen.out_row !== want.out_row ||
              seen.out_col !== want.out_col || seen.end_of_frame !== want.end_of_frame ||
              seen.last_of_run !== want.last_of_run) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("mismatch: expected %0d/%0d/%0d/%0b/%0b got %0d/%0d/%0d/%0b/%0b",
                       want.edge_value, want.out_row, want.out_col, want.end_of_frame,
                       want.last_of_run, seen.edge_value, seen.out_row, seen.out_col,
                       seen.end_of_frame, seen.last_of_run);
          end
        end
      end
      if (pattern_left == 0) begin
        stall_style  = $urandom_range(0, 3);
        pattern_left = $urandom_range(40, 250);
      end else begin
        pattern_left--;
      end
      case (stall_style)
        0:       take = 1'b1;                            // always ready
        1:       take = ($urandom_range(0, 3) != 0);     // sparse random stalls
        2:       take = (pattern_left % 4 != 0);         // periodic stall
        default: take = ($urandom_range(0, 1) == 1);     // heavy random stalls
      endcase
      edge_ch.ready <= take && !receiver_hold;
    end
  end

  // --------------------------------------------------------------------------
  // stimulus: register phases, each followed by its frames of requests
  // --------------------------------------------------------------------------
  function automatic void push_request(logic kind, logic [PIX_W-1:0] px);
    pixel_request_t rq;
    rq.kind  = kind;
    rq.pixel = px;
    requests_to_send.push_back(rq);
  endfunction

  // registers but the height are narrower than the port; upper bits get junk half the time
  function automatic logic [CFG_W-1:0] pad_upper(int unsigned value, int bits);
    logic [CFG_W-1:0] d;
    d = CFG_W'(value);
    if (bits < CFG_W && $urandom_range(0, 1) == 1) d = d | (CFG_W'($urandom) << bits);
    return d;
  endfunction

  task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_FRAME_WIDTH: begin
        width_reg = data[FW_W-1:0];
        restart_frame();
      end
      REG_FRAME_HEIGHT: begin
        height_reg = data[FH_W-1:0];
        restart_frame();
      end
      REG_FOUR_BIT_MODE:    four_bit_reg = data[0];
      REG_THRESHOLD_ENABLE: thr_en_reg   = data[0];
      REG_THRESHOLD_HIGH:   thr_reg      = data[PIX_W-1:0];
      default: ;
    endcase
  endtask

  task automatic configure(int unsigned w, int unsigned h, bit four, bit thr_on,
                           int unsigned thr);
    write_reg(REG_FRAME_WIDTH, pad_upper(w, FW_W));
    write_reg(REG_FRAME_HEIGHT, CFG_W'(h));
    write_reg(REG_FOUR_BIT_MODE, pad_upper(four, 1));
    write_reg(REG_THRESHOLD_ENABLE, pad_upper(thr_on, 1));
    write_reg(REG_THRESHOLD_HIGH, pad_upper(thr, PIX_W));
  endtask

  // all requests accepted, all results back, then room for a result still in
  // the pipe behind a request that causes none
  task automatic wait_idle();
    do @(negedge clk); while (requests_to_send.size() != 0 || pix_ch.valid);
    while (edge_results_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  int unsigned w_val, h_val, w, h, thr, npix, nflush, frames, style, small_count;
  int          phase, i, f;
  bit          partial, wide;
  logic [PIX_W-1:0] px;

  initial begin
    cfg_we          = 1'b0;
    cfg_index       = REG_FRAME_WIDTH;
    cfg_data        = '0;
    // predictor matches the block right after reset
    width_reg    = MAX_WIDTH;
    height_reg   = 1024;
    four_bit_reg = 1'b0;
    thr_en_reg   = 1'b0;
    thr_reg      = 8'd128;
    for (i = 0; i < 9; i++) win_px[i] = '0;
    for (i = 0; i < MAX_WIDTH; i++) begin
      upper_line[i] = '0;
      lower_line[i] = '0;
    end
    restart_frame();

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: smallest frame, bright centre on black, then dark centre in
    // bright corners; stray flush before the frame, stray pixel in the drain
    configure(3, 3, 1'b0, 1'b0, 128);
    @(negedge clk);
    push_request(REQ_FLUSH, 8'd0);
    for (i = 0; i < 9; i++) push_request(REQ_PIXEL, (i == 4) ? 8'd255 : 8'd0);
    push_request(REQ_PIXEL, 8'd255);
    for (i = 0; i < 3; i++) push_request(REQ_FLUSH, 8'd255);
    for (i = 0; i < 9; i++) push_request(REQ_PIXEL, (i == 4) ? 8'd0 : 8'd255);
    for (i = 0; i < 3; i++) push_request(REQ_FLUSH, 8'd0);

    // random phases: small frames with random content, broken and abandoned
    // frames now and then, one wide partial frame and one pressure phase
    small_count = 0;
    phase       = 0;
    while (small_count < SMALL_ITEMS) begin
      phase++;
      wait_idle();
      wide = (phase == WIDE_PHASE);
      case ($urandom_range(0, 9))
        0:       w_val = $urandom_range(0, 2);
        1:       w_val = $urandom_range(13, 24);
        default: w_val = $urandom_range(3, 12);
      endcase
      case ($urandom_range(0, 9))
        0:       h_val = $urandom_range(0, 2);
        1:       h_val = $urandom_range(MAX_HEIGHT, 8191);
        default: h_val = $urandom_range(3, 8);
      endcase
      if (wide) begin
        w_val = 2047;
        h_val = 8191;
      end else if (phase == PRESSURE_PHASE) begin
        w_val = 8;
        h_val = 6;
      end
      case ($urandom_range(0, 3))
        0:       thr = 0;
        1:       thr = 255;
        default: thr = $urandom_range(0, 255);
      endcase
      if ($urandom_range(0, 1) == 1 && thr > 20) thr = $urandom_range(0, 17);
      configure(w_val, h_val, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), thr);
      w      = active_width();
      h      = active_height();
      style  = $urandom_range(0, 3);
      partial = wide || h >= MAX_HEIGHT || $urandom_range(0, 5) == 0;
      frames = partial ? 1 : $urandom_range(1, 2);
      @(negedge clk);
      for (f = 0; f < frames; f++) begin
        // wide frame reaches into the second row, past the saturated width
        if (wide) npix = w + 5;
        else if (h >= MAX_HEIGHT) npix = $urandom_range(2 * w, 6 * w);
        else if (partial) npix = $urandom_range(1, w * h - 1);
        else npix = w * h;
        nflush = partial ? 0 : (($urandom_range(0, 7) == 0) ? $urandom_range(1, w - 1) : w);
        for (i = 0; i < npix; i++) begin
          // a flush mid-frame is noise the block must ignore
          if (!wide && $urandom_range(0, 39) == 0) push_request(REQ_FLUSH, PIX_W'($urandom));
          case (style)
            0:       px = PIX_W'($urandom_range(0, 255));
            1:       px = ($urandom_range(0, 1) == 1) ? 8'd255 : 8'd0;
            2:       px = PIX_W'($urandom_range(0, 2));
            default: px = PIX_W'((i % w) * 20 + $urandom_range(0, 15));
          endcase
          push_request(REQ_PIXEL, px);
        end
        if (nflush > 0 && $urandom_range(0, 2) == 0) push_request(REQ_PIXEL, PIX_W'($urandom));
        for (i = 0; i < nflush; i++) push_request(REQ_FLUSH, PIX_W'($urandom));
      end
      small_count += requests_to_send.size();
      if (phase == PRESSURE_PHASE) begin
        // receiver holds off while the sender keeps offering requests
        receiver_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        receiver_hold <= 1'b0;
      end
    end

    wait_idle();
    if (mismatch_count == 0 && edge_results_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // run limit, far above the slowest correct run
  initial begin
    #(12_000_000);
    $display("TB_ERROR");
    $finish;
  end

endmodule

FILE: contrast_normalized_edge_top.f
design/cne_pkg.sv
design/cne_if.sv
design/cne_ram.sv
design/cne_divider.sv
design/contrast_normalized_edge_top.sv
bench/tb_contrast_normalized_edge_top.sv
